[design/tpd_pkg.sv]
// Shared types and constants for the touch pad press detector.
`default_nettype none

package tpd_pkg;

   localparam int CAL_SAMPLES_DEF    = 10;
   localparam int TRIM_EACH_SIDE_DEF = 2;
   localparam int TIMER_BITS         = 16;
   localparam int SAMPLE_BITS        = 16;
   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = 16'd50;

   typedef enum logic [1:0] {
      MODE_RELEASED    = 2'd0,
      MODE_TOUCHED     = 2'd1,
      MODE_CALIBRATING = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'd0,
      SEQ_RANK = 2'd1,
      SEQ_DIV  = 2'd2
   } seq_type;

endpackage

`default_nettype wire

[design/touch_pad_press_detector_top.sv]
// Latency: a request's result is registered and offered in the cycle after acceptance.
// Throughput: one request per cycle while no unaccepted response holds it, except the last
// calibration sample, whose result is offered only once the baseline is ready, after
// a rank sweep over the sample memory's two read ports, then a reciprocal multiply.
// Reset (synchronous, active high): calibrating, count and baseline zero, threshold 50;
// the sample memory is not cleared and is always written before it is read.
`default_nettype none

module touch_pad_press_detector_top #(
   parameter int CAL_SAMPLES    = tpd_pkg::CAL_SAMPLES_DEF,
   parameter int TRIM_EACH_SIDE = tpd_pkg::TRIM_EACH_SIDE_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tpd_pkg::SAMPLE_BITS-1:0]  csr_touch_threshold,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [tpd_pkg::TIMER_BITS-1:0]   req_start_count,
   input  wire logic [tpd_pkg::TIMER_BITS-1:0]   req_capture_count,
   input  wire logic                             req_recalibrate,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [tpd_pkg::TIMER_BITS:0]          rsp_charge_time,
   output logic                                  rsp_touch_level,
   output logic                                  rsp_press_event,
   output logic                                  rsp_calibrated,
   output logic [tpd_pkg::SAMPLE_BITS-1:0]       rsp_baseline_value
);

   import tpd_pkg::*;

   localparam int N        = CAL_SAMPLES;
   localparam int TRIM_EFF = (TRIM_EACH_SIDE > (N - 1) / 2) ? (N - 1) / 2 : TRIM_EACH_SIDE;
   localparam int KEEP     = N - 2 * TRIM_EFF;
   localparam int IW       = $clog2(N);
   localparam int CW       = $clog2(N + 1);
   localparam int SW       = SAMPLE_BITS + IW;
   localparam int KW       = $clog2(KEEP);
   localparam int RS       = SW + KW;
   localparam int CTW      = TIMER_BITS + 1;
   localparam logic [IW:0] RANK_LO = (IW + 1)'(TRIM_EFF);
   localparam logic [IW:0] RANK_HI = (IW + 1)'(N - TRIM_EFF);
   localparam longint unsigned RECIP = ((64'd1 << RS) + 64'(KEEP) - 64'd1) / 64'(KEEP);
   localparam logic [SW+1:0] RECIP_W = (SW + 2)'(RECIP);

   // sample memory
   logic [SAMPLE_BITS-1:0] store_mem [N];
   logic                   store_we;
   logic [IW-1:0]          store_waddr;
   logic [SAMPLE_BITS-1:0] store_wdata;
   logic [SAMPLE_BITS-1:0] rd_a_ff, rd_b_ff;

   seq_type                seq_ff, seq_in;
   mode_type               mode_ff, mode_in, mode_v;
   logic [CW-1:0]          cnt_ff, cnt_in, cnt_v;
   logic [SAMPLE_BITS-1:0] base_ff, base_in, base_v;
   logic [SAMPLE_BITS-1:0] thr_ff, thr_in;
   logic [CTW-1:0]         ct_ff, ct_in;

   logic                   iss_on_ff, iss_on_in;
   logic [IW-1:0]          iss_i_ff, iss_i_in, iss_j_ff, iss_j_in;
   logic                   pv_ff, pv_in;
   logic [IW-1:0]          pi_ff, pi_in, pj_ff, pj_in;
   logic [IW-1:0]          rank_ff, rank_in, rank_next;
   logic [SW-1:0]          sum_ff, sum_in, sum_next;
   logic [2*SW+1:0]        prod;
   logic [SAMPLE_BITS-1:0] quot;
   logic                   less, keep;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CTW-1:0]         rsp_ct_ff, rsp_ct_in;
   logic                   rsp_level_ff, rsp_level_in;
   logic                   rsp_press_ff, rsp_press_in;
   logic                   rsp_cal_ff, rsp_cal_in;
   logic [SAMPLE_BITS-1:0] rsp_base_ff, rsp_base_in;

   logic [TIMER_BITS-1:0]  diff;
   logic [CTW-1:0]         ct_w;
   logic [SAMPLE_BITS-1:0] ct_sat;
   logic [CTW-1:0]         limit;
   logic                   touched;

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_charge_time    = rsp_ct_ff;
   assign rsp_touch_level    = rsp_level_ff;
   assign rsp_press_event    = rsp_press_ff;
   assign rsp_calibrated     = rsp_cal_ff;
   assign rsp_baseline_value = rsp_base_ff;

   assign diff   = req_capture_count - req_start_count;
   assign ct_w   = (diff == '0) ? {1'b1, {TIMER_BITS{1'b0}}} : {1'b0, diff};
   assign ct_sat = ct_w[TIMER_BITS] ? {SAMPLE_BITS{1'b1}} : ct_w[SAMPLE_BITS-1:0];

   // rank compare: ties are broken by memory index so every rank is unique
   assign less      = (rd_b_ff < rd_a_ff) || ((rd_b_ff == rd_a_ff) && (pj_ff < pi_ff));
   assign rank_next = rank_ff + IW'(less);
   assign keep      = ({1'b0, rank_next} >= RANK_LO) && ({1'b0, rank_next} < RANK_HI);

   // divide the kept-sample sum by the kept count through a scaled reciprocal
   assign prod = {{(SW + 2){1'b0}}, sum_ff} * {{SW{1'b0}}, RECIP_W};
   assign quot = prod[RS +: SAMPLE_BITS];

   always_comb begin
      seq_in       = seq_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      thr_in       = thr_ff;
      ct_in        = ct_ff;
      iss_on_in    = iss_on_ff;
      iss_i_in     = iss_i_ff;
      iss_j_in     = iss_j_ff;
      pv_in        = 1'b0;
      pi_in        = iss_i_ff;
      pj_in        = iss_j_ff;
      rank_in      = rank_ff;
      sum_in       = sum_ff;
      sum_next     = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ct_in    = rsp_ct_ff;
      rsp_level_in = rsp_level_ff;
      rsp_press_in = rsp_press_ff;
      rsp_cal_in   = rsp_cal_ff;
      rsp_base_in  = rsp_base_ff;
      store_we     = 1'b0;
      store_waddr  = cnt_ff[IW-1:0];
      store_wdata  = ct_sat;
      limit        = {1'b0, base_ff} + {1'b0, thr_ff};
      touched      = 1'b0;
      mode_v       = mode_ff;
      cnt_v        = cnt_ff;
      base_v       = base_ff;

      if (csr_valid) begin
         thr_in = csr_touch_threshold;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      req_ready = (seq_ff == SEQ_IDLE) && (!rsp_valid_ff || rsp_ready);

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_valid && req_ready) begin
               mode_v  = req_recalibrate ? MODE_CALIBRATING : mode_ff;
               cnt_v   = req_recalibrate ? '0 : cnt_ff;
               base_v  = req_recalibrate ? '0 : base_ff;
               ct_in   = ct_w;
               base_in = base_v;
               limit   = {1'b0, base_v} + {1'b0, thr_ff};
               if (mode_v == MODE_CALIBRATING) begin
                  store_we    = 1'b1;
                  store_waddr = cnt_v[IW-1:0];
                  cnt_in      = cnt_v + CW'(1);
                  mode_in     = MODE_CALIBRATING;
                  if (cnt_v == CW'(N - 1)) begin
                     // last sample: hold the result until the baseline is ready
                     seq_in    = SEQ_RANK;
                     iss_on_in = 1'b1;
                     iss_i_in  = '0;
                     iss_j_in  = '0;
                     rank_in   = '0;
                     sum_in    = '0;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_ct_in    = ct_w;
                     rsp_level_in = 1'b0;
                     rsp_press_in = 1'b0;
                     rsp_cal_in   = 1'b0;
                     rsp_base_in  = base_v;
                  end
               end else begin
                  touched      = ct_w > limit;
                  mode_in      = touched ? MODE_TOUCHED : MODE_RELEASED;
                  rsp_valid_in = 1'b1;
                  rsp_ct_in    = ct_w;
                  rsp_level_in = touched;
                  rsp_press_in = touched && (mode_v == MODE_RELEASED);
                  rsp_cal_in   = 1'b1;
                  rsp_base_in  = base_v;
               end
            end
         end
         SEQ_RANK: begin
            // issue one (i, j) read pair per cycle
            if (iss_on_ff) begin
               pv_in = 1'b1;
               if (iss_j_ff == IW'(N - 1)) begin
                  iss_j_in = '0;
                  iss_i_in = iss_i_ff + IW'(1);
                  if (iss_i_ff == IW'(N - 1)) begin
                     iss_on_in = 1'b0;
                  end
               end else begin
                  iss_j_in = iss_j_ff + IW'(1);
               end
            end
            if (pv_ff) begin
               if (pj_ff == IW'(N - 1)) begin
                  sum_next = sum_ff + (keep ? SW'(rd_a_ff) : '0);
                  sum_in   = sum_next;
                  rank_in  = '0;
                  if (pi_ff == IW'(N - 1)) begin
                     seq_in = SEQ_DIV;
                  end
               end else begin
                  rank_in = rank_next;
               end
            end
         end
         SEQ_DIV: begin
            seq_in       = SEQ_IDLE;
            base_in      = quot;
            mode_in      = MODE_RELEASED;
            rsp_valid_in = 1'b1;
            rsp_ct_in    = ct_ff;
            rsp_level_in = 1'b0;
            rsp_press_in = 1'b0;
            rsp_cal_in   = 1'b1;
            rsp_base_in  = quot;
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      rd_a_ff <= store_mem[iss_i_ff];
      rd_b_ff <= store_mem[iss_j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         mode_ff      <= MODE_CALIBRATING;
         cnt_ff       <= '0;
         base_ff      <= '0;
         thr_ff       <= THRESHOLD_RESET;
         iss_on_ff    <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         base_ff      <= base_in;
         thr_ff       <= thr_in;
         iss_on_ff    <= iss_on_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ct_ff        <= ct_in;
      iss_i_ff     <= iss_i_in;
      iss_j_ff     <= iss_j_in;
      pi_ff        <= pi_in;
      pj_ff        <= pj_in;
      rank_ff      <= rank_in;
      sum_ff       <= sum_in;
      rsp_ct_ff    <= rsp_ct_in;
      rsp_level_ff <= rsp_level_in;
      rsp_press_ff <= rsp_press_in;
      rsp_cal_ff   <= rsp_cal_in;
      rsp_base_ff  <= rsp_base_in;
   end

`ifndef SYNTHESIS
   a_no_rsp_during_sweep: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SEQ_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while baseline sweep runs");

   a_read_pair_only_in_rank: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> (seq_ff == SEQ_RANK))
      else $error("read pair returned outside rank sweep");

   a_press_implies_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_press_ff) |-> (rsp_level_ff && rsp_cal_ff))
      else $error("press event without touch level");

   a_uncal_zero_baseline: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_cal_ff) |-> (rsp_base_ff == '0))
      else $error("nonzero baseline reported while calibrating");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_CALIBRATING && seq_ff == SEQ_IDLE) |-> (cnt_ff < CW'(N)))
      else $error("sample count ran past the calibration depth");
`endif

endmodule

`default_nettype wire
